@@ design/mcpos_pkg.sv @@
package mcpos_pkg;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned LEN_W      = 32;
  localparam int unsigned CHAN_W     = 8;
  localparam int unsigned WIN_W      = 16;
  localparam int unsigned OUT_BITS   = 32;

  localparam logic [LEN_W-1:0] MAX_LENGTH_RST   = 32'd100000;
  localparam logic [LEN_W-1:0] MIN_LENGTH_RST   = 32'd100;
  localparam logic [WIN_W-1:0] OFF_WINDOW_RST   = 16'd50;
  localparam logic [WIN_W-1:0] LATENCY_COMP_RST = 16'd10;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_LENGTH   = 2'd0,
    CFG_MIN_LENGTH   = 2'd1,
    CFG_OFF_WINDOW   = 2'd2,
    CFG_LATENCY_COMP = 2'd3
  } cfg_reg_e;

  typedef enum logic {
    FUNC_PLAY = 1'b0,
    FUNC_TICK = 1'b1
  } func_e;

  typedef enum logic [1:0] {
    LEN_CL_NONE = 2'd0,
    LEN_CL_MAX  = 2'd1,
    LEN_CL_MIN  = 2'd2
  } len_cl_e;

  typedef struct packed {
    logic              func;
    logic [CHAN_W-1:0] channel;
    logic [LEN_W-1:0]  pulse_length;
  } in_item_t;

  typedef struct packed {
    logic [OUT_BITS-1:0] outputs_on;
    logic                refused;
    logic                channel_clamped;
    logic [1:0]          length_clamped;
    logic                missed;
    logic                fired;
  } out_item_t;

  typedef struct packed {
    logic latch;     // capture accepted transaction
    logic exec;      // apply tick or play
    logic scan_step; // walk the off-time memory
    logic scan_end;  // fold min into compare, settle counter
    logic load_out;  // move result into output register
  } cmd_t;

  typedef struct packed {
    logic need_scan;
    logic scan_done;
  } status_t;

endpackage

@@ design/multi_channel_pulse_off_scheduler.sv @@
// Pulse scheduler for NUM_CHANNELS outputs against a TIME_BITS tick counter. Each
// transaction (play or tick) yields one result. A tick that does not reach the compare
// time and a refused play go from the execute state straight to the finish state, which
// loads the result register. A play that switches a channel on, and a tick that hits the
// compare time, walk the off-time memory one entry per cycle to find the earliest off
// time (a tick also switches off due channels); that walk through the single read
// port of the off-time RAM sets the rate. The input is ready again in the cycle after the
// result is loaded. A new transaction is taken once the previous result sits in the
// output register, even while it is still waiting to be read; the next result then
// waits until that read. No clearing pass after reset: the per-channel on bits mark
// which off times are live.
module multi_channel_pulse_off_scheduler #(
  parameter int unsigned NUM_CHANNELS = 32,
  parameter int unsigned TIME_BITS    = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [mcpos_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [mcpos_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  mcpos_pkg::in_item_t              in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output mcpos_pkg::out_item_t             out_data_o
);

  mcpos_pkg::cmd_t    cmd;
  mcpos_pkg::status_t status;

  mcpos_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  mcpos_datapath #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .TIME_BITS    (TIME_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_data_i),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .status_o    (status)
  );

endmodule

@@ design/mcpos_ram.sv @@
module mcpos_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  logic                                         clk_i,
  input  logic                                         we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                             wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                             rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

@@ design/mcpos_datapath.sv @@
module mcpos_datapath #(
  parameter int unsigned NUM_CHANNELS = 32,
  parameter int unsigned TIME_BITS    = 32
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [mcpos_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [mcpos_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  input  mcpos_pkg::in_item_t                in_data_i,
  output mcpos_pkg::out_item_t               out_data_o,
  input  mcpos_pkg::cmd_t                    cmd_i,
  output mcpos_pkg::status_t                 status_o
);

  localparam int unsigned CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam logic [CH_W:0] LAST_IDX = (CH_W + 1)'(NUM_CHANNELS);
  localparam logic [CH_W-1:0] TOP_CH = CH_W'(NUM_CHANNELS - 1);
  localparam logic [mcpos_pkg::CHAN_W-1:0] NCH_8 = mcpos_pkg::CHAN_W'(NUM_CHANNELS);

  // configuration
  logic [mcpos_pkg::LEN_W-1:0] max_len_q, min_len_q;
  logic [mcpos_pkg::WIN_W-1:0] win_q, lat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= mcpos_pkg::MAX_LENGTH_RST;
      min_len_q <= mcpos_pkg::MIN_LENGTH_RST;
      win_q     <= mcpos_pkg::OFF_WINDOW_RST;
      lat_q     <= mcpos_pkg::LATENCY_COMP_RST;
    end else if (cfg_we_i) begin
      unique case (mcpos_pkg::cfg_reg_e'(cfg_idx_i))
        mcpos_pkg::CFG_MAX_LENGTH:   max_len_q <= cfg_wdata_i;
        mcpos_pkg::CFG_MIN_LENGTH:   min_len_q <= cfg_wdata_i;
        mcpos_pkg::CFG_OFF_WINDOW:   win_q     <= cfg_wdata_i[mcpos_pkg::WIN_W-1:0];
        mcpos_pkg::CFG_LATENCY_COMP: lat_q     <= cfg_wdata_i[mcpos_pkg::WIN_W-1:0];
        default: ;
      endcase
    end
  end

  // transaction capture with clamping
  logic                        func_q, ch_cl_q;
  logic [CH_W-1:0]             ch_q;
  logic [mcpos_pkg::LEN_W-1:0] len_q;
  logic [1:0]                  len_cl_q;

  logic                        ch_over;
  logic [mcpos_pkg::LEN_W-1:0] len_a, len_b;
  logic [1:0]                  len_cl_a, len_cl_b;

  always_comb begin
    ch_over  = in_data_i.channel >= NCH_8;
    len_a    = in_data_i.pulse_length;
    len_cl_a = mcpos_pkg::LEN_CL_NONE;
    if (len_a >= max_len_q) begin
      len_a    = max_len_q;
      len_cl_a = mcpos_pkg::LEN_CL_MAX;
    end
    len_b    = len_a;
    len_cl_b = len_cl_a;
    if (len_a <= min_len_q) begin
      len_b    = min_len_q;
      len_cl_b = mcpos_pkg::LEN_CL_MIN;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      func_q   <= in_data_i.func;
      ch_q     <= ch_over ? TOP_CH : in_data_i.channel[CH_W-1:0];
      ch_cl_q  <= ch_over;
      len_q    <= len_b;
      len_cl_q <= len_cl_b;
    end
  end

  // timing state
  logic [NUM_CHANNELS-1:0] on_q, on_d;
  logic [TIME_BITS-1:0]    count_q, count_d, cmp_q, cmp_d;
  logic [TIME_BITS-1:0]    cnt_inc, off_new, win_end, lo_q, lo_d, eff, cnt_end;
  logic [CH_W:0]           idx_q, idx_d;
  logic [CH_W-1:0]         rd_idx_q;
  logic                    rd_vld_q, rd_vld_d;
  logic                    is_tick, match, busy_ch, ram_we, due;
  logic [TIME_BITS-1:0]    rdata;

  logic refused_q, refused_d, missed_q, missed_d, fired_q, fired_d;

  assign is_tick = (func_q == mcpos_pkg::FUNC_TICK);
  assign cnt_inc = count_q + TIME_BITS'(1);
  assign match   = (cnt_inc == cmp_q);
  assign busy_ch = on_q[ch_q];
  assign off_new = count_q + len_q[TIME_BITS-1:0] - TIME_BITS'(lat_q);
  assign win_end = cmp_q + TIME_BITS'(win_q);
  assign ram_we  = cmd_i.exec && !is_tick && !busy_ch;
  assign eff     = on_q[rd_idx_q] ? rdata : '1;
  assign due     = is_tick && (eff >= cmp_q) && (eff <= win_end);
  // counter returns to zero once a switch-off pass leaves every channel off
  assign cnt_end = (is_tick && (on_q == '0)) ? '0 : count_q;

  assign status_o.need_scan = is_tick ? match : !busy_ch;
  assign status_o.scan_done = (idx_q == LAST_IDX) && !rd_vld_q;

  mcpos_ram #(
    .WIDTH (TIME_BITS),
    .DEPTH (NUM_CHANNELS)
  ) u_off_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ch_q),
    .wdata_i (off_new),
    .raddr_i (idx_q[CH_W-1:0]),
    .rdata_o (rdata)
  );

  always_comb begin
    on_d      = on_q;
    count_d   = count_q;
    cmp_d     = cmp_q;
    idx_d     = idx_q;
    rd_vld_d  = 1'b0;
    lo_d      = lo_q;
    refused_d = refused_q;
    missed_d  = missed_q;
    fired_d   = fired_q;
    if (cmd_i.exec) begin
      idx_d     = '0;
      lo_d      = '1;
      missed_d  = 1'b0;
      refused_d = 1'b0;
      fired_d   = 1'b0;
      if (is_tick) begin
        count_d = cnt_inc;
        fired_d = match;
      end else if (busy_ch) begin
        refused_d = 1'b1;
      end else begin
        on_d[ch_q] = 1'b1;
      end
    end
    if (cmd_i.scan_step) begin
      if (idx_q != LAST_IDX) begin
        idx_d    = idx_q + (CH_W + 1)'(1);
        rd_vld_d = 1'b1;
      end
      if (rd_vld_q) begin
        if (due) begin
          on_d[rd_idx_q] = 1'b0;
        end else if (eff < lo_q) begin
          lo_d = eff;
        end
      end
    end
    if (cmd_i.scan_end) begin
      count_d  = cnt_end;
      missed_d = lo_q < cnt_end;
      if (!(lo_q < cnt_end)) begin
        cmp_d = lo_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      on_q     <= '0;
      count_q  <= '0;
      cmp_q    <= '1;
      idx_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      on_q     <= on_d;
      count_q  <= count_d;
      cmp_q    <= cmp_d;
      idx_q    <= idx_d;
      rd_vld_q <= rd_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q  <= idx_q[CH_W-1:0];
    lo_q      <= lo_d;
    refused_q <= refused_d;
    missed_q  <= missed_d;
    fired_q   <= fired_d;
  end

  // result register
  logic [mcpos_pkg::OUT_BITS-1:0] on_vis;

  for (genvar i = 0; i < mcpos_pkg::OUT_BITS; i++) begin : g_vis
    if (i < NUM_CHANNELS) begin : g_on
      assign on_vis[i] = on_q[i];
    end else begin : g_off
      assign on_vis[i] = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_data_o.outputs_on      <= on_vis;
      out_data_o.refused         <= refused_q;
      out_data_o.channel_clamped <= is_tick ? 1'b0 : ch_cl_q;
      out_data_o.length_clamped  <= is_tick ? mcpos_pkg::LEN_CL_NONE : len_cl_q;
      out_data_o.missed          <= missed_q;
      out_data_o.fired           <= fired_q;
    end
  end

endmodule

@@ design/mcpos_ctrl.sv @@
module mcpos_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output mcpos_pkg::cmd_t    cmd_o,
  input  mcpos_pkg::status_t status_i
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_EXEC   = 4'b0010,
    S_SCAN   = 4'b0100,
    S_FINISH = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = status_i.need_scan ? S_SCAN : S_FINISH;
      end
      S_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (status_i.scan_done) begin
          cmd_o.scan_end = 1'b1;
          state_d        = S_FINISH;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

@@ tb/sv/pulse_sched_checker.sv @@
module pulse_sched_checker #(
  parameter int unsigned NUM_CHANNELS = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [mcpos_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [mcpos_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                             in_valid_i,
  input  logic                             in_ready_i,
  input  mcpos_pkg::in_item_t              in_data_i,
  input  logic                             out_valid_i,
  input  logic                             out_ready_i,
  input  mcpos_pkg::out_item_t             out_data_i,
  output int unsigned                      err_cnt_o
);

  typedef logic [31:0] tstamp_t;

  logic [mcpos_pkg::LEN_W-1:0] max_len;
  logic [mcpos_pkg::LEN_W-1:0] min_len;
  logic [mcpos_pkg::WIN_W-1:0] off_win;
  logic [mcpos_pkg::WIN_W-1:0] lat_comp;

  tstamp_t                 off_time [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] ch_on;
  tstamp_t                 tick_cnt;
  tstamp_t                 cmp_time;

  mcpos_pkg::out_item_t exp_results [$];
  int unsigned          mismatches = 0;

  assign err_cnt_o = mismatches;

  // earliest off time becomes the compare value unless it is already behind the counter
  function automatic logic refresh_compare();
    tstamp_t lo;
    lo = '1;
    for (int k = 0; k < NUM_CHANNELS; k++) begin
      if (off_time[k] < lo) lo = off_time[k];
    end
    if (lo < tick_cnt) return 1'b1;
    cmp_time = lo;
    return 1'b0;
  endfunction

  function automatic mcpos_pkg::out_item_t sched_step(mcpos_pkg::in_item_t it);
    mcpos_pkg::out_item_t        r;
    int                          ch;
    logic [mcpos_pkg::LEN_W-1:0] len;
    tstamp_t                     last;
    logic                        all_off;
    r = '0;
    if (it.func == mcpos_pkg::FUNC_TICK) begin
      tick_cnt = tick_cnt + 1;
      if (tick_cnt == cmp_time) begin
        r.fired = 1'b1;
        last    = cmp_time + tstamp_t'(off_win);
        all_off = 1'b1;
        for (int k = 0; k < NUM_CHANNELS; k++) begin
          if (off_time[k] >= cmp_time && off_time[k] <= last) begin
            ch_on[k]    = 1'b0;
            off_time[k] = '1;
          end
          if (ch_on[k]) all_off = 1'b0;
        end
        if (all_off) tick_cnt = '0;
        r.missed = refresh_compare();
      end
    end else begin
      ch  = int'(it.channel);
      len = it.pulse_length;
      if (ch >= int'(NUM_CHANNELS)) begin
        ch                = int'(NUM_CHANNELS) - 1;
        r.channel_clamped = 1'b1;
      end
      if (len >= max_len) begin
        len              = max_len;
        r.length_clamped = mcpos_pkg::LEN_CL_MAX;
      end
      // a max below min ends up at min, reported as raised
      if (len <= min_len) begin
        len              = min_len;
        r.length_clamped = mcpos_pkg::LEN_CL_MIN;
      end
      if (ch_on[ch]) begin
        r.refused = 1'b1;
      end else begin
        ch_on[ch]    = 1'b1;
        off_time[ch] = tick_cnt + len - tstamp_t'(lat_comp);
        r.missed     = refresh_compare();
      end
    end
    for (int k = 0; k < int'(NUM_CHANNELS) && k < int'(mcpos_pkg::OUT_BITS); k++) begin
      r.outputs_on[k] = ch_on[k];
    end
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t %s mismatch: expected %h actual %h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    mcpos_pkg::out_item_t want;
    if (!rst_ni) begin
      max_len  <= mcpos_pkg::MAX_LENGTH_RST;
      min_len  <= mcpos_pkg::MIN_LENGTH_RST;
      off_win  <= mcpos_pkg::OFF_WINDOW_RST;
      lat_comp <= mcpos_pkg::LATENCY_COMP_RST;
      for (int k = 0; k < NUM_CHANNELS; k++) off_time[k] = '1;
      ch_on    = '0;
      tick_cnt = '0;
      cmp_time = '1;
      exp_results.delete();
    end else begin
      if (cfg_we_i) begin
        unique case (mcpos_pkg::cfg_reg_e'(cfg_idx_i))
          mcpos_pkg::CFG_MAX_LENGTH:   max_len  <= cfg_wdata_i[mcpos_pkg::LEN_W-1:0];
          mcpos_pkg::CFG_MIN_LENGTH:   min_len  <= cfg_wdata_i[mcpos_pkg::LEN_W-1:0];
          mcpos_pkg::CFG_OFF_WINDOW:   off_win  <= cfg_wdata_i[mcpos_pkg::WIN_W-1:0];
          mcpos_pkg::CFG_LATENCY_COMP: lat_comp <= cfg_wdata_i[mcpos_pkg::WIN_W-1:0];
          default: ;
        endcase
      end
      // results first: a result can never belong to the transaction taken at the same edge
      if (out_valid_i && out_ready_i) begin
        if (exp_results.size() == 0) begin
          $display("%0t result with no transaction pending: expected none actual %h",
                   $time, out_data_i);
          mismatches++;
        end else begin
          want = exp_results.pop_front();
          check_field("outputs_on", want.outputs_on, out_data_i.outputs_on);
          check_field("refused", 32'(want.refused), 32'(out_data_i.refused));
          check_field("channel_clamped", 32'(want.channel_clamped),
                      32'(out_data_i.channel_clamped));
          check_field("length_clamped", 32'(want.length_clamped),
                      32'(out_data_i.length_clamped));
          check_field("missed", 32'(want.missed), 32'(out_data_i.missed));
          check_field("fired", 32'(want.fired), 32'(out_data_i.fired));
        end
      end
      if (in_valid_i && in_ready_i) exp_results.push_back(sched_step(in_data_i));
    end
  end

endmodule

@@ tb/sv/tb.sv @@
module tb;

  localparam int unsigned WATCHDOG_LIMIT = 2000;

  logic                             clk       = 1'b0;
  logic                             rst_n     = 1'b0;
  logic                             cfg_we    = 1'b0;
  logic [mcpos_pkg::CFG_IDX_W-1:0]  cfg_idx   = '0;
  logic [mcpos_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                             in_valid  = 1'b0;
  logic                             in_ready;
  mcpos_pkg::in_item_t              in_data   = '0;
  logic                             out_valid;
  logic                             out_ready = 1'b0;
  mcpos_pkg::out_item_t             out_data;
  int unsigned                      err_cnt;

  int unsigned sent         = 0;
  int unsigned recv         = 0;
  int unsigned idle_cycles  = 0;
  int unsigned src_idle_pct = 20;
  int unsigned rdy_idle_pct = 10;
  int unsigned stall_left   = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  multi_channel_pulse_off_scheduler #(
    .NUM_CHANNELS(32),
    .TIME_BITS   (32)
  ) DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  pulse_sched_checker #(
    .NUM_CHANNELS(32)
  ) sched_chk (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata),
    .in_valid_i (in_valid),
    .in_ready_i (in_ready),
    .in_data_i  (in_data),
    .out_valid_i(out_valid),
    .out_ready_i(out_ready),
    .out_data_i (out_data),
    .err_cnt_o  (err_cnt)
  );

  always @(posedge clk) begin
    if (in_valid && in_ready) sent <= sent + 1;
    if (out_valid && out_ready) recv <= recv + 1;
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  // receiver stalls in bursts, each started with a chance of rdy_idle_pct percent
  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 99) < rdy_idle_pct) begin
      out_ready  <= 1'b0;
      stall_left <= $urandom_range(0, 7);
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic send_item(input mcpos_pkg::in_item_t it);
    int unsigned gap;
    if (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct) begin
      gap = $urandom_range(1, 8);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_play(input logic [mcpos_pkg::CHAN_W-1:0] ch,
                           input logic [mcpos_pkg::LEN_W-1:0] len);
    mcpos_pkg::in_item_t it;
    it.func         = mcpos_pkg::FUNC_PLAY;
    it.channel      = ch;
    it.pulse_length = len;
    send_item(it);
  endtask

  // channel and length are don't-care on a tick, so fill them with noise
  task automatic send_tick();
    mcpos_pkg::in_item_t it;
    it.func         = mcpos_pkg::FUNC_TICK;
    it.channel      = mcpos_pkg::CHAN_W'($urandom);
    it.pulse_length = $urandom;
    send_item(it);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sent != recv) @(posedge clk);
  endtask

  task automatic load_config(input logic [31:0] max_l, input logic [31:0] min_l,
                             input logic [31:0] win, input logic [31:0] lat);
    drain();
    cfg_we    <= 1'b1;
    cfg_idx   <= mcpos_pkg::CFG_MAX_LENGTH;
    cfg_wdata <= max_l;
    @(posedge clk);
    cfg_idx   <= mcpos_pkg::CFG_MIN_LENGTH;
    cfg_wdata <= min_l;
    @(posedge clk);
    cfg_idx   <= mcpos_pkg::CFG_OFF_WINDOW;
    cfg_wdata <= win;
    @(posedge clk);
    cfg_idx   <= mcpos_pkg::CFG_LATENCY_COMP;
    cfg_wdata <= lat;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic run_random(input int unsigned n, input int unsigned play_pct,
                            input logic [mcpos_pkg::LEN_W-1:0] span);
    logic [mcpos_pkg::CHAN_W-1:0] ch;
    logic [mcpos_pkg::LEN_W-1:0]  len;
    for (int unsigned i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < play_pct) begin
        if ($urandom_range(0, 6) == 0) ch = mcpos_pkg::CHAN_W'($urandom_range(32, 255));
        else ch = mcpos_pkg::CHAN_W'($urandom_range(0, 31));
        case ($urandom_range(0, 9))
          0:       len = $urandom;
          1:       len = '1;
          default: len = $urandom_range(0, span);
        endcase
        send_play(ch, len);
      end else begin
        send_tick();
      end
    end
  endtask

  initial begin : watchdog
    while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("FAIL multi_channel_pulse_off_scheduler");
    $finish;
  end

  initial begin : stimulus
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // clamps, refusals and a fire that takes several channels at once
    load_config(32'd60, 32'd6, 32'd3, 32'd4);
    send_play(8'd0, 32'd0);
    send_play(8'd255, 32'hFFFF_FFFF);
    send_play(8'd0, 32'd5);
    send_play(8'h55, 32'h5555_5555);
    send_play(8'hAA, 32'hAAAA_AAAA);
    send_play(8'd3, 32'd7);
    send_play(8'd4, 32'd9);
    send_play(8'd5, 32'd10);
    repeat (6) send_tick();

    // max below min: every length lands on min
    load_config(32'd5, 32'd8, 32'd0, 32'd2);
    send_play(8'd1, 32'd4);
    send_play(8'd2, 32'd100);
    repeat (6) send_tick();

    // every played length stays above latency_comp here, so no off time falls behind
    load_config(32'd40, 32'd8, 32'd3, 32'd2);
    run_random(180, 25, 32'd50);

    src_idle_pct = 0;
    rdy_idle_pct <= 30;
    load_config(32'd200, 32'd30, 32'd0, 32'd29);
    run_random(150, 20, 32'd250);

    src_idle_pct = 30;
    rdy_idle_pct <= 0;
    load_config(32'd25, 32'd25, 32'd65535, 32'd0);
    run_random(150, 30, 32'd40);

    src_idle_pct = 0;
    load_config(32'd10, 32'd60, 32'd7, 32'd5);
    run_random(120, 25, 32'd80);

    src_idle_pct = 15;
    rdy_idle_pct <= 15;
    load_config(mcpos_pkg::MAX_LENGTH_RST, mcpos_pkg::MIN_LENGTH_RST,
                32'(mcpos_pkg::OFF_WINDOW_RST), 32'(mcpos_pkg::LATENCY_COMP_RST));
    run_random(120, 10, 32'd300);

    // off times that wrap or fall behind the counter can stall the compare for good,
    // so they come last
    src_idle_pct = 0;
    rdy_idle_pct <= 0;
    load_config(32'hFFFF_FFFF, 32'd0, 32'd65535, 32'd65535);
    run_random(60, 50, 32'd20);
    // upper bits of the 16-bit registers are dropped
    load_config(32'd0, 32'hFFFF_FFFF, 32'hFFFF_0000, 32'h0001_0000);
    run_random(50, 50, 32'd20);

    drain();
    repeat (40) @(posedge clk);
    if (err_cnt == 0) begin
      $display("PASS multi_channel_pulse_off_scheduler");
    end else begin
      $display("FAIL multi_channel_pulse_off_scheduler");
    end
    $finish;
  end

endmodule

@@ multi_channel_pulse_off_scheduler.f @@
design/mcpos_pkg.sv
design/mcpos_ram.sv
design/mcpos_datapath.sv
design/mcpos_ctrl.sv
design/multi_channel_pulse_off_scheduler.sv
tb/sv/pulse_sched_checker.sv
tb/sv/tb.sv
